FILE: rtl/lifd_pkg.sv
package lifd_pkg;

  localparam logic [5:0] ADDR_RESET = 6'd46;
  localparam logic [5:0] ADDR_MAX = 6'd50;
  localparam logic [5:0] ADDR_RESP_LO = 6'd46;
  localparam logic [5:0] ADDR_RESP_HI = 6'd48;

  localparam logic [3:0] FRAME_LEN_OK = 4'd6;
  localparam logic [7:0] HDR_A = 8'h81;
  localparam logic [7:0] HDR_B = 8'h00;

  localparam logic [8:0] HOLD_UP = 9'd6;
  localparam logic [8:0] HOLD_DOWN = 9'd2;
  localparam logic [8:0] HOLD_CEIL = 9'd500;

  localparam logic [5:0] CODE_OVERLOAD = 6'h39;
  localparam logic [5:0] CODE_SPECIAL_LO = 6'h33;
  localparam logic [5:0] CODE_SPECIAL_HI = 6'h3B;
  localparam logic [5:0] CODE_SUB_LO = 6'h29;
  localparam logic [5:0] CODE_SUB_HI = 6'h31;
  localparam logic [5:0] CODE_SEISMIC = 6'h33;
  localparam logic [5:0] CODE_FIREMAN = 6'h35;
  localparam logic [5:0] CODE_MAINT = 6'h37;
  localparam logic [5:0] CODE_EVAC = 6'h38;
  localparam logic [5:0] CODE_FIRE = 6'h39;
  localparam logic [5:0] CODE_LADING = 6'h3B;

  localparam logic [7:0] FLAG_OVERLOAD = 8'h01;
  localparam logic [7:0] FLAG_FIRE = 8'h02;
  localparam logic [7:0] FLAG_MAINT = 8'h04;
  localparam logic [7:0] FLAG_FIREMAN = 8'h08;
  localparam logic [7:0] FLAG_EVAC = 8'h10;
  localparam logic [7:0] FLAG_LADING = 8'h20;
  localparam logic [7:0] FLAG_SEISMIC = 8'h40;
  localparam logic [7:0] FLAG_ERROR = 8'h80;

  localparam logic [5:0] SYM_HYPHEN = 6'd22;
  localparam logic [1:0] RESP_PREFIX = 2'b10;

  localparam logic [1:0] STATUS_DECODED = 2'd0;
  localparam logic [1:0] STATUS_IGNORED = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  message_byte;
    logic [7:0]  floor_byte;
    logic [7:0]  signal_byte;
  } lifd_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] floor_number;
    logic [1:0] symbol_count;
    logic [5:0] first_symbol;
    logic [5:0] second_symbol;
    logic [7:0] mode_flags;
    logic [1:0] direction;
    logic       gong_on;
    logic       cabin_moving;
    logic       respond;
    logic [7:0] response_id;
  } lifd_out_t;

  typedef struct packed {
    logic [8:0] hold_count;
    logic [7:0] mode_bits;
    logic [5:0] shown_floor;
    logic [1:0] text_length;
    logic [5:0] text_first;
    logic [5:0] text_second;
    logic [1:0] arrow_state;
    logic       gong_state;
    logic       moving_state;
  } lifd_state_t;

endpackage

FILE: rtl/lift_indicator_frame_decoder.sv
// Lift indicator frame decoder.
// The input channel (in_valid, in_ready, in_data) carries one received bus
// frame per request. The output channel (out_valid, out_ready, out_data)
// returns exactly one result per frame, in order, with a decode status, the
// display state and the acknowledge information.
// The indicator address is written through cfg_we and cfg_wdata; values above
// 50 are clamped to 50. Write it only while no frame is in flight.
// A frame is registered in the input stage on acceptance, decoded against the
// held state and placed in the output register once that register is free or
// being emptied; out_valid rises when the output register is loaded.
// Without an output stall one frame can be accepted every cycle; the rate is
// set by the single decode stage that updates hold counter and display state.
// Synchronous reset clears both stages, the hold counter, the mode flags and
// the display state, and restores the indicator address to 46.
// When the receiver holds out_ready low, the result waits in the output
// register and the input stage holds one more frame; in_ready then drops.
module lift_indicator_frame_decoder import lifd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lifd_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lifd_out_t  out_data,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);

  logic        s1_valid_r;
  lifd_in_t    s1_data_r;
  logic        out_valid_r;
  lifd_out_t   out_data_r;
  lifd_state_t state_r;
  lifd_state_t state_nxt;
  lifd_out_t   result_nxt;
  logic [5:0]  addr_r;
  logic        advance;

  assign advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  lifd_decode u_decode (
    .frame      (s1_data_r),
    .state      (state_r),
    .addr       (addr_r),
    .state_nxt  (state_nxt),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
      addr_r <= ADDR_RESET;
    end else begin
      if (cfg_we) begin
        addr_r <= (cfg_wdata > ADDR_MAX) ? ADDR_MAX : cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        state_r <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result_nxt;
    end
  end

endmodule

FILE: rtl/lifd_decode.sv
module lifd_decode import lifd_pkg::*; (
  input  lifd_in_t    frame,
  input  lifd_state_t state,
  input  logic [5:0]  addr,
  output lifd_state_t state_nxt,
  output lifd_out_t   result_nxt
);

  function automatic logic [8:0] hold_attack(input logic [8:0] h);
    logic [9:0] s;
    s = {1'b0, h} + {1'b0, HOLD_UP};
    return (s > {1'b0, HOLD_CEIL}) ? HOLD_CEIL : s[8:0];
  endfunction

  function automatic logic [7:0] special_flag(input logic [5:0] code);
    logic [7:0] f;
    case (code)
      CODE_SEISMIC: f = FLAG_SEISMIC;
      CODE_FIREMAN: f = FLAG_FIREMAN;
      CODE_MAINT:   f = FLAG_MAINT;
      CODE_EVAC:    f = FLAG_EVAC;
      CODE_FIRE:    f = FLAG_FIRE;
      CODE_LADING:  f = FLAG_LADING;
      default:      f = FLAG_ERROR;
    endcase
    return f;
  endfunction

  function automatic logic [5:0] tens_of(input logic [5:0] code);
    logic [5:0] t;
    if (code >= 6'd40) t = 6'd4;
    else if (code >= 6'd30) t = 6'd3;
    else if (code >= 6'd20) t = 6'd2;
    else if (code >= 6'd10) t = 6'd1;
    else t = 6'd0;
    return t;
  endfunction

  logic       id_match;
  logic       len_ok;
  logic       hdr_ok;
  logic [1:0] status;
  logic [5:0] msg_code;
  logic [5:0] flr_code;
  logic       overload;
  logic       special;
  logic       ordinary;
  logic [8:0] hold_1;
  logic [7:0] mode_1;
  logic [5:0] tens;
  logic       respond;

  assign id_match = (frame.frame_id == {5'd0, addr});
  assign len_ok = (frame.frame_len == FRAME_LEN_OK);
  assign hdr_ok = (frame.header_first == HDR_A) && (frame.header_second == HDR_B);
  assign msg_code = frame.message_byte[5:0];
  assign flr_code = frame.floor_byte[5:0];
  assign overload = (msg_code == CODE_OVERLOAD);
  assign special = (flr_code >= CODE_SPECIAL_LO) && (flr_code <= CODE_SPECIAL_HI);
  assign ordinary = (flr_code <= CODE_SUB_HI);
  assign hold_1 = overload ? hold_attack(state.hold_count) : state.hold_count;
  assign mode_1 = overload ? (state.mode_bits | FLAG_OVERLOAD) : state.mode_bits;
  assign tens = tens_of(flr_code);
  assign respond = (addr >= ADDR_RESP_LO) && (addr <= ADDR_RESP_HI) && !frame.signal_byte[7];

  always_comb begin
    if (!id_match) begin
      status = STATUS_IGNORED;
    end else if (!len_ok) begin
      status = STATUS_MALFORMED;
    end else if (!hdr_ok) begin
      status = STATUS_IGNORED;
    end else begin
      status = STATUS_DECODED;
    end
  end

  always_comb begin
    state_nxt = state;
    if (status == STATUS_DECODED) begin
      state_nxt.hold_count = hold_1;
      state_nxt.mode_bits = mode_1;
      if (special) begin
        state_nxt.hold_count = hold_attack(hold_1);
        state_nxt.mode_bits = (mode_1 & FLAG_OVERLOAD) | special_flag(flr_code);
      end else if (ordinary) begin
        // Release only acts on a nonzero counter; reaching zero drops every flag.
        if (hold_1 != 9'd0) begin
          if (hold_1 <= HOLD_DOWN) begin
            state_nxt.hold_count = 9'd0;
            state_nxt.mode_bits = 8'd0;
          end else begin
            state_nxt.hold_count = hold_1 - HOLD_DOWN;
          end
        end
        if (flr_code >= CODE_SUB_LO) begin
          state_nxt.text_length = 2'd2;
          state_nxt.text_first = SYM_HYPHEN;
          state_nxt.text_second = flr_code - CODE_SUB_LO + 6'd1;
        end else if (flr_code < 6'd10) begin
          state_nxt.text_length = 2'd1;
          state_nxt.text_first = flr_code;
          state_nxt.text_second = 6'd0;
        end else begin
          state_nxt.text_length = 2'd2;
          state_nxt.text_first = tens;
          state_nxt.text_second = flr_code - 6'(tens * 6'd10);
        end
        state_nxt.shown_floor = flr_code;
      end
      state_nxt.gong_state = frame.signal_byte[2];
      state_nxt.moving_state = frame.signal_byte[4];
      state_nxt.arrow_state = frame.signal_byte[1:0];
    end
  end

  always_comb begin
    result_nxt = '0;
    result_nxt.status = status;
    result_nxt.response_id = {RESP_PREFIX, addr};
    if (status == STATUS_DECODED) begin
      result_nxt.floor_number = state_nxt.shown_floor;
      result_nxt.symbol_count = state_nxt.text_length;
      result_nxt.first_symbol = state_nxt.text_first;
      result_nxt.second_symbol = state_nxt.text_second;
      result_nxt.mode_flags = state_nxt.mode_bits;
      result_nxt.direction = state_nxt.arrow_state;
      result_nxt.gong_on = state_nxt.gong_state;
      result_nxt.cabin_moving = state_nxt.moving_state;
      result_nxt.respond = respond;
    end
  end

endmodule

FILE: rtl/lifd_checker.sv
module lifd_checker import lifd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input lifd_in_t   in_data,
  input logic       out_valid,
  input logic       out_ready,
  input lifd_out_t  out_data,
  input logic       cfg_we,
  input logic [5:0] cfg_wdata
);

  logic unused_ok;
  assign unused_ok = in_valid ^ in_ready ^ (^in_data) ^ cfg_we ^ (^cfg_wdata);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_not_decoded_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_DECODED |->
      out_data.mode_flags == 8'd0 && out_data.respond == 1'b0 &&
      out_data.symbol_count == 2'd0 && out_data.direction == 2'd0)
    else $error("fields set on a frame that was not decoded");

  a_resp_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.response_id[7:6] == RESP_PREFIX &&
      out_data.response_id[5:0] <= ADDR_MAX)
    else $error("response id out of range");

  a_respond_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.respond |->
      out_data.response_id[5:0] >= ADDR_RESP_LO &&
      out_data.response_id[5:0] <= ADDR_RESP_HI)
    else $error("respond set for an address without that role");

endmodule

bind lift_indicator_frame_decoder lifd_checker u_lifd_checker (.*);

FILE: tb/sv/lifd_tb_pkg.sv
package lifd_tb_pkg;
  import lifd_pkg::*;

  class indicator_scoreboard;
    logic [5:0] address;
    logic [8:0] hold_level;
    logic [7:0] active_modes;
    logic [5:0] floor_shown;
    logic [1:0] sym_count;
    logic [5:0] sym_first;
    logic [5:0] sym_second;
    logic [1:0] arrow;
    logic       gong;
    logic       moving;
    lifd_out_t  expected_q[$];
    int         errors;
    int         decoded_cnt;
    int         ignored_cnt;
    int         malformed_cnt;
    int         hold_peak;
    int         flag_clears;

    function new();
      address = ADDR_RESET;
      hold_level = '0;
      active_modes = '0;
      floor_shown = '0;
      sym_count = '0;
      sym_first = '0;
      sym_second = '0;
      arrow = '0;
      gong = 1'b0;
      moving = 1'b0;
      errors = 0;
      decoded_cnt = 0;
      ignored_cnt = 0;
      malformed_cnt = 0;
      hold_peak = 0;
      flag_clears = 0;
    endfunction

    function void set_address(logic [5:0] value);
      address = (value > ADDR_MAX) ? ADDR_MAX : value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void raise_hold();
      logic [9:0] sum;
      sum = {1'b0, hold_level} + {1'b0, HOLD_UP};
      hold_level = (sum > {1'b0, HOLD_CEIL}) ? HOLD_CEIL : sum[8:0];
      if (hold_level > hold_peak) hold_peak = hold_level;
    endfunction

    function void note_request(lifd_in_t f);
      lifd_out_t  r;
      logic [5:0] code;
      logic [7:0] flag;
      r = '0;
      r.response_id = {RESP_PREFIX, address};
      if (f.frame_id != 11'(address)) begin
        r.status = STATUS_IGNORED;
      end else if (f.frame_len != FRAME_LEN_OK) begin
        r.status = STATUS_MALFORMED;
      end else if (f.header_first != HDR_A || f.header_second != HDR_B) begin
        r.status = STATUS_IGNORED;
      end else begin
        r.status = STATUS_DECODED;
        r.respond = (address >= ADDR_RESP_LO && address <= ADDR_RESP_HI &&
                     !f.signal_byte[7]);
        if (f.message_byte[5:0] == CODE_OVERLOAD) begin
          raise_hold();
          active_modes = active_modes | FLAG_OVERLOAD;
        end
        code = f.floor_byte[5:0];
        if (code >= CODE_SPECIAL_LO && code <= CODE_SPECIAL_HI) begin
          case (code)
            CODE_SEISMIC: flag = FLAG_SEISMIC;
            CODE_FIREMAN: flag = FLAG_FIREMAN;
            CODE_MAINT: flag = FLAG_MAINT;
            CODE_EVAC: flag = FLAG_EVAC;
            CODE_FIRE: flag = FLAG_FIRE;
            CODE_LADING: flag = FLAG_LADING;
            default: flag = FLAG_ERROR;
          endcase
          raise_hold();
          active_modes = (active_modes & FLAG_OVERLOAD) | flag;
        end else if (code <= CODE_SUB_HI) begin
          // A release only clears the flags on the step that brings the counter to zero.
          if (hold_level != '0) begin
            hold_level = (hold_level <= HOLD_DOWN) ? 9'd0 : hold_level - HOLD_DOWN;
            if (hold_level == '0) begin
              active_modes = '0;
              flag_clears++;
            end
          end
          if (code >= CODE_SUB_LO) begin
            sym_count = 2'd2;
            sym_first = SYM_HYPHEN;
            sym_second = code - CODE_SUB_LO + 6'd1;
          end else if (code < 6'd10) begin
            sym_count = 2'd1;
            sym_first = code;
            sym_second = '0;
          end else begin
            sym_count = 2'd2;
            sym_first = code / 6'd10;
            sym_second = code % 6'd10;
          end
          floor_shown = code;
        end
        gong = f.signal_byte[2];
        moving = f.signal_byte[4];
        arrow = f.signal_byte[1:0];
        r.floor_number = floor_shown;
        r.symbol_count = sym_count;
        r.first_symbol = sym_first;
        r.second_symbol = sym_second;
        r.mode_flags = active_modes;
        r.direction = arrow;
        r.gong_on = gong;
        r.cabin_moving = moving;
      end
      case (r.status)
        STATUS_DECODED: decoded_cnt++;
        STATUS_MALFORMED: malformed_cnt++;
        default: ignored_cnt++;
      endcase
      expected_q.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(lifd_out_t got);
      lifd_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with none expected", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare("status", 8'(want.status), 8'(got.status));
      compare("floor_number", 8'(want.floor_number), 8'(got.floor_number));
      compare("symbol_count", 8'(want.symbol_count), 8'(got.symbol_count));
      compare("first_symbol", 8'(want.first_symbol), 8'(got.first_symbol));
      compare("second_symbol", 8'(want.second_symbol), 8'(got.second_symbol));
      compare("mode_flags", want.mode_flags, got.mode_flags);
      compare("direction", 8'(want.direction), 8'(got.direction));
      compare("gong_on", 8'(want.gong_on), 8'(got.gong_on));
      compare("cabin_moving", 8'(want.cabin_moving), 8'(got.cabin_moving));
      compare("respond", 8'(want.respond), 8'(got.respond));
      compare("response_id", want.response_id, got.response_id);
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_top.sv
module tb_top;
  import lifd_pkg::*;
  import lifd_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 60;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [10:0] OWN_ID = 11'(ADDR_RESET);

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  lifd_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  lifd_out_t  out_data;
  logic       cfg_we;
  logic [5:0] cfg_wdata;

  int send_pct;
  int recv_pct;
  int cycle_count;
  int hold_offs;
  bit long_hold;
  indicator_scoreboard sb;

  lift_indicator_frame_decoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_request(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with requests still outstanding.", cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  function automatic lifd_in_t frame(logic [10:0] id, logic [3:0] len, logic [7:0] h0,
                                     logic [7:0] h1, logic [7:0] msg, logic [7:0] flr,
                                     logic [7:0] sig);
    lifd_in_t f;
    f = {id, len, h0, h1, msg, flr, sig};
    return f;
  endfunction

  task automatic send_frame(lifd_in_t f);
    @(negedge clk);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_and_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(logic [5:0] addr_value, int send_idle, int recv_stall,
                           int attack, int count, bit with_hold);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= addr_value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_address(addr_value);
    send_pct = send_idle;
    recv_pct = recv_stall;
    for (int i = 0; i < count; i++) begin
      lifd_in_t    f;
      logic [5:0]  code;
      int unsigned r;
      if (with_hold && i == count / 4) begin
        long_hold = 1'b1;
        hold_offs++;
      end
      f.frame_id = 11'(sb.address);
      f.frame_len = FRAME_LEN_OK;
      f.header_first = HDR_A;
      f.header_second = HDR_B;
      f.message_byte = 8'($urandom);
      f.signal_byte = 8'($urandom);
      r = $urandom_range(99);
      if (r < attack) begin
        code = 6'($urandom_range(CODE_SPECIAL_LO, CODE_SPECIAL_HI));
      end else if (r < attack + 5) begin
        code = ($urandom_range(4) == 0) ? CODE_SUB_HI + 6'd1 :
               6'($urandom_range(CODE_SPECIAL_HI + 1, 63));
      end else begin
        code = 6'($urandom_range(CODE_SUB_HI));
      end
      f.floor_byte = {2'($urandom), code};
      if ($urandom_range(99) < attack / 2) f.message_byte[5:0] = CODE_OVERLOAD;
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(3))
          0: f.frame_len = 4'($urandom_range(8));
          1: begin
            f.header_first = 8'($urandom);
            if ($urandom_range(1) == 1) f.header_second = 8'($urandom_range(1, 255));
          end
          2: f.frame_id = f.frame_id ^ (11'd1 << $urandom_range(10));
          default: begin
            f.frame_id = 11'($urandom);
            f.frame_len = 4'($urandom_range(8));
            f.header_first = 8'($urandom);
            f.header_second = 8'($urandom);
          end
        endcase
      end
      send_frame(f);
    end
    stop_and_drain();
  endtask

  initial begin
    int code;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_pct = 0;
    recv_pct = 0;
    hold_offs = 0;
    long_hold = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames at the reset address, starting from a cleared hold counter.
    send_frame(frame(11'h7FF, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, 8'h05, 8'h00));
    send_frame(frame(OWN_ID, 4'd0, HDR_A, HDR_B, 8'h00, 8'h05, 8'h00));
    send_frame(frame(OWN_ID, 4'd8, HDR_A, HDR_B, 8'h00, 8'h05, 8'h00));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, 8'h80, HDR_B, 8'h00, 8'h05, 8'h00));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, 8'hFF, 8'h00, 8'h05, 8'h00));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, 8'h00, 8'h00));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, 8'hC9, 8'h01));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, 8'h0A, 8'h02));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, {2'b01, CODE_SUB_LO},
                     8'h04));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, {2'b10, CODE_SUB_HI},
                     8'h90));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00,
                     {2'b00, CODE_SUB_HI + 6'd1}, 8'h00));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00,
                     {2'b11, CODE_SPECIAL_HI + 6'd1}, 8'h00));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h3F, 8'hFF, 8'h00));
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, {2'b11, CODE_OVERLOAD},
                     {2'b00, CODE_LADING}, 8'hFF));
    for (code = CODE_SPECIAL_LO; code <= CODE_SPECIAL_HI; code++) begin
      send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, {2'b10, 6'(code)},
                       8'h13));
    end
    send_frame(frame(OWN_ID, FRAME_LEN_OK, HDR_A, HDR_B, 8'h00, 8'h19, 8'h00));
    stop_and_drain();

    run_phase(6'h3F, 0, 0, 15, 80, 1'b0);
    run_phase(6'd47, 0, 66, 10, 100, 1'b0);
    run_phase(6'd0, 66, 0, 20, 80, 1'b0);
    run_phase(6'd48, 13, 13, 10, 60, 1'b0);
    run_phase(ADDR_RESET, 0, 0, 75, 130, 1'b1);
    run_phase(6'd21, 13, 13, 50, 100, 1'b0);

    $display("Checked %0d decoded, %0d ignored and %0d malformed frames across six addresses.",
             sb.decoded_cnt, sb.ignored_cnt, sb.malformed_cnt);
    $display("Hold counter peaked at %0d, flags cleared on release %0d times, %0d long stalls.",
             sb.hold_peak, sb.flag_clears, hold_offs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
